/* hw/rtl/bdpc_pkg.sv */
// Shared types, register indexes and button ordering for the button debounce classifier.
package bdpc_pkg;

  localparam int unsigned BtnW     = 2;
  localparam int unsigned CfgW     = 16;
  localparam int unsigned CfgAddrW = 1;
  localparam int unsigned OutDataW = 8;

  // Configuration register indexes
  localparam logic [CfgAddrW-1:0] CfgDebounce  = 1'b0;
  localparam logic [CfgAddrW-1:0] CfgLongPress = 1'b1;

  // Event kinds
  localparam logic KindShort = 1'b0;
  localparam logic KindLong  = 1'b1;

  // Status handed from a cell to the top level
  typedef struct packed {
    logic hit;   // this cell owns the event of the transaction
    logic kind;  // long or short press
  } cell_status_t;

  typedef struct packed {
    logic [BtnW-1:0] button;
    logic            kind;
  } event_t;

  // Button checked at chain position pos: ok, back, left, right, then the rest.
  function automatic int unsigned btn_at(int unsigned pos, int unsigned n);
    int unsigned res;
    res = pos;
    if (n >= 4) begin
      if (pos < 2) begin
        res = pos + 2;
      end else if (pos < 4) begin
        res = pos - 2;
      end
    end else if (n == 3) begin
      res = (pos == 0) ? 2 : pos - 1;
    end
    return res;
  endfunction

endpackage

/* hw/rtl/bdpc_cell.sv */
// One button cell: debounce state, press tracking and the priority chain link.
module bdpc_cell #(
  parameter int unsigned TIME_WIDTH = 32
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        en_i,
  input  logic [TIME_WIDTH-1:0]       now_i,
  input  logic                        raw_i,
  input  logic [bdpc_pkg::CfgW-1:0]   debounce_i,
  input  logic [bdpc_pkg::CfgW-1:0]   long_press_i,
  input  logic                        taken_i,
  output logic                        taken_o,
  output bdpc_pkg::cell_status_t      status_o
);

  logic                  stable_q, stable_d;
  logic                  last_raw_q;
  logic [TIME_WIDTH-1:0] change_q, change_d;
  logic                  held_q, held_d;
  logic [TIME_WIDTH-1:0] start_q, start_d;
  logic                  long_rep_q, long_rep_d;
  logic                  click_q, click_d;

  logic [TIME_WIDTH-1:0] since_change;
  logic [TIME_WIDTH-1:0] since_press;
  logic                  settle;
  logic                  long_ev;
  logic                  short_ev;
  logic                  grant;

  always_comb begin
    change_d   = (raw_i != last_raw_q) ? now_i : change_q;
    since_change = now_i - change_d;
    settle     = (since_change >= TIME_WIDTH'(debounce_i)) && (stable_q != raw_i);
    stable_d   = stable_q;
    held_d     = held_q;
    start_d    = start_q;
    long_rep_d = long_rep_q;
    click_d    = click_q;
    if (settle) begin
      stable_d = raw_i;
      if (!raw_i) begin
        held_d     = 1'b1;
        start_d    = now_i;
        long_rep_d = 1'b0;
        click_d    = 1'b1;
      end else begin
        held_d = 1'b0;
      end
    end

    since_press = now_i - start_d;
    long_ev  = held_d && !long_rep_d && (since_press >= TIME_WIDTH'(long_press_i));
    short_ev = !held_d && !long_rep_d && click_d;
    grant    = (long_ev || short_ev) && !taken_i;

    // only the cell that wins the chain consumes its event
    if (grant) begin
      if (long_ev) begin
        long_rep_d = 1'b1;
      end else begin
        click_d = 1'b0;
      end
    end
  end

  assign taken_o       = taken_i || long_ev || short_ev;
  assign status_o.hit  = grant;
  assign status_o.kind = long_ev ? bdpc_pkg::KindLong : bdpc_pkg::KindShort;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stable_q   <= 1'b1;
      last_raw_q <= 1'b1;
      change_q   <= '0;
      held_q     <= 1'b0;
      start_q    <= '0;
      long_rep_q <= 1'b0;
      click_q    <= 1'b0;
    end else if (en_i) begin
      stable_q   <= stable_d;
      last_raw_q <= raw_i;
      change_q   <= change_d;
      held_q     <= held_d;
      start_q    <= start_d;
      long_rep_q <= long_rep_d;
      click_q    <= click_d;
    end
  end

endmodule

/* hw/rtl/bdpc_out_buf.sv */
// Output register with a skid stage for event transactions.
module bdpc_out_buf (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  bdpc_pkg::event_t    data_i,
  output logic                space_o,
  output logic                valid_o,
  input  logic                ready_i,
  output bdpc_pkg::event_t    data_o
);

  logic             out_valid_q;
  logic             skid_valid_q;
  bdpc_pkg::event_t out_q;
  bdpc_pkg::event_t skid_q;
  logic             pop;

  assign pop     = out_valid_q && ready_i;
  assign space_o = !skid_valid_q;
  assign valid_o = out_valid_q;
  assign data_o  = out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (skid_valid_q) begin
      if (pop) begin
        out_valid_q  <= 1'b1;
        skid_valid_q <= 1'b0;
      end
    end else if (!out_valid_q || pop) begin
      out_valid_q <= push_i;
    end else if (push_i) begin
      skid_valid_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (skid_valid_q) begin
      if (pop) begin
        out_q <= skid_q;
      end
    end else if (!out_valid_q || pop) begin
      out_q <= data_i;
    end else if (push_i) begin
      skid_q <= data_i;
    end
  end

endmodule

/* hw/rtl/button_debounce_press_classifier_core.sv */
// Events are registered in the output register or skid stage before m_axis.
// One poll tick per cycle while s_axis_tready is high; button state updates on accept.
// The row of button cells resolves event priority through its chain in the same cycle.
// Input stalls only when both the output register and the skid stage hold events.
// Reset: all buttons released and idle, debounce_ms = 30, long_press_ms = 1000.
// Top level of the button debounce and press classifier.
module button_debounce_press_classifier_core #(
  parameter int unsigned NUM_BUTTONS = 4,
  parameter int unsigned TIME_WIDTH  = 32
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [bdpc_pkg::CfgAddrW-1:0]     cfg_addr_i,
  input  logic [bdpc_pkg::CfgW-1:0]         cfg_wdata_i,
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  // now_ms, raw_left, raw_right, raw_ok, raw_back, further buttons, zero fill
  input  logic [((TIME_WIDTH+NUM_BUTTONS+7)/8)*8-1:0] s_axis_tdata,
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  // event_button, zero fill
  output logic [bdpc_pkg::OutDataW-1:0]     m_axis_tdata,
  // event_kind
  output logic                              m_axis_tuser
);

  logic [bdpc_pkg::CfgW-1:0] debounce_q;
  logic [bdpc_pkg::CfgW-1:0] long_press_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      debounce_q   <= bdpc_pkg::CfgW'(30);
      long_press_q <= bdpc_pkg::CfgW'(1000);
    end else if (cfg_we_i) begin
      unique case (cfg_addr_i)
        bdpc_pkg::CfgDebounce:  debounce_q   <= cfg_wdata_i;
        bdpc_pkg::CfgLongPress: long_press_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  logic                   accept;
  logic                   space;
  logic [TIME_WIDTH-1:0]  now;
  logic [NUM_BUTTONS:0]   taken;
  bdpc_pkg::cell_status_t status [NUM_BUTTONS];
  logic [bdpc_pkg::BtnW-1:0] btn_code [NUM_BUTTONS];
  bdpc_pkg::event_t       evt;
  bdpc_pkg::event_t       out_evt;

  assign s_axis_tready = space;
  assign accept        = s_axis_tvalid && space;
  assign now           = s_axis_tdata[TIME_WIDTH-1:0];
  assign taken[0]      = 1'b0;

  // cells sit in priority order along the chain
  for (genvar p = 0; p < NUM_BUTTONS; p++) begin : g_cell
    localparam int unsigned Btn = bdpc_pkg::btn_at(p, NUM_BUTTONS);

    bdpc_cell #(
      .TIME_WIDTH(TIME_WIDTH)
    ) u_cell (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .en_i         (accept),
      .now_i        (now),
      .raw_i        (s_axis_tdata[TIME_WIDTH+Btn]),
      .debounce_i   (debounce_q),
      .long_press_i (long_press_q),
      .taken_i      (taken[p]),
      .taken_o      (taken[p+1]),
      .status_o     (status[p])
    );

    assign btn_code[p] = bdpc_pkg::BtnW'(Btn);
  end

  always_comb begin
    evt = '0;
    for (int unsigned p = 0; p < NUM_BUTTONS; p++) begin
      if (status[p].hit) begin
        evt.button = evt.button | btn_code[p];
        evt.kind   = evt.kind | status[p].kind;
      end
    end
  end

  bdpc_out_buf u_out_buf (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (accept && taken[NUM_BUTTONS]),
    .data_i  (evt),
    .space_o (space),
    .valid_o (m_axis_tvalid),
    .ready_i (m_axis_tready),
    .data_o  (out_evt)
  );

  assign m_axis_tdata = bdpc_pkg::OutDataW'(out_evt.button);
  assign m_axis_tuser = out_evt.kind;

endmodule
